/* design/ntm_pkg.sv */
`timescale 1ns / 1ps
package ntm_pkg;

    // One markup request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_valid;
        logic       end_of_markup;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] tag_begin;
        logic [15:0] tag_end;
        logic [2:0]  status;
        logic        run_last;
    } t_out_item;

    // All results of one request: cnt is 0, 1 or 2
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  r0;
        t_out_item  r1;
    } t_entry;

    localparam logic [2:0] KIND_TEXT     = 3'd0;
    localparam logic [2:0] KIND_TAG      = 3'd1;
    localparam logic [2:0] KIND_NAME     = 3'd2;
    localparam logic [2:0] KIND_NAME_END = 3'd3;
    localparam logic [2:0] KIND_STATUS   = 3'd4;

endpackage

/* design/ntm_req_if.sv */
`timescale 1ns / 1ps
interface ntm_req_if
    import ntm_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/ntm_res_if.sv */
`timescale 1ns / 1ps
interface ntm_res_if
    import ntm_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/ntm_ram.sv */
`timescale 1ns / 1ps
module ntm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port; read returns old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/ntm_parse.sv */
`timescale 1ns / 1ps
module ntm_parse
    import ntm_pkg::*;
#(
    parameter int STACK_DEPTH   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_acc,
    input  t_in_item i_item,
    output logic     o_push,
    output t_entry   o_entry
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PB = POSITION_BITS;
    localparam int RamDepth = 1 << AW;

    localparam logic [2:0] MODE_TEXT        = 3'd0;
    localparam logic [2:0] MODE_QUOTE       = 3'd1;
    localparam logic [2:0] MODE_NAME        = 3'd2;
    localparam logic [2:0] MODE_NAME_QUOTED = 3'd3;
    localparam logic [2:0] MODE_NAME_ESCAPE = 3'd4;
    localparam logic [2:0] MODE_HALT        = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TRAIL      = 3'd1;
    localparam logic [2:0] ST_NO_OPEN    = 3'd2;
    localparam logic [2:0] ST_OPEN_NAME  = 3'd3;
    localparam logic [2:0] ST_UNCLOSED   = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_TOO_LONG   = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    logic [2:0]    r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [PB-1:0] r_len, n_len;
    logic [2:0]    r_err, n_err;
    logic          r_fwd_hit, n_fwd_hit;
    logic [PB-1:0] r_fwd_data;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [CW-1:0] rd_sub;
    logic [PB-1:0] ram_rdata;
    logic [PB-1:0] top;

    logic          do_text;
    logic          have0;
    t_out_item     res_byte;
    t_out_item     res_st;
    logic [2:0]    st;
    logic [7:0]    c;

    // Stack of open positions
    ntm_ram #(
        .WIDTH (PB),
        .DEPTH (RamDepth)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_len),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Top of stack: last cycle's push bypasses the RAM
    assign top = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign c   = i_item.in_byte;

    // Mode update, stack access and results of one request
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_len    = r_len;
        n_err    = r_err;
        we       = 1'b0;
        waddr    = r_count[AW-1:0];
        do_text  = 1'b0;
        have0    = 1'b0;
        res_byte = '0;
        res_st   = '0;
        st       = ST_OK;
        o_entry  = '0;

        if (i_acc && i_item.byte_valid) begin
            case (r_mode)
                MODE_TEXT: begin
                    do_text = 1'b1;
                end
                MODE_QUOTE: begin
                    if (c == CH_OPEN) begin
                        if (r_count == '0) begin
                            n_err  = ST_NO_OPEN;
                            n_mode = MODE_HALT;
                        end else begin
                            n_count            = r_count - CW'(1);
                            have0              = 1'b1;
                            res_byte.kind      = KIND_TAG;
                            res_byte.tag_begin = 16'(top);
                            res_byte.tag_end   = 16'(r_len);
                            n_mode             = MODE_NAME;
                        end
                    end else if (r_count >= CW'(STACK_DEPTH)) begin
                        n_err  = ST_FULL;
                        n_mode = MODE_HALT;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                        n_mode  = MODE_TEXT;
                        do_text = 1'b1;
                    end
                end
                MODE_NAME: begin
                    have0 = 1'b1;
                    if (c == CH_CLOSE) begin
                        res_byte.kind = KIND_NAME_END;
                        n_mode        = MODE_TEXT;
                    end else begin
                        res_byte.kind     = KIND_NAME;
                        res_byte.out_byte = c;
                        if (c == CH_DQUOTE) begin
                            n_mode = MODE_NAME_QUOTED;
                        end
                    end
                end
                MODE_NAME_QUOTED: begin
                    have0             = 1'b1;
                    res_byte.kind     = KIND_NAME;
                    res_byte.out_byte = c;
                    if (c == CH_DQUOTE) begin
                        n_mode = MODE_NAME;
                    end else if (c == CH_BSLASH) begin
                        n_mode = MODE_NAME_ESCAPE;
                    end
                end
                MODE_NAME_ESCAPE: begin
                    have0             = 1'b1;
                    res_byte.kind     = KIND_NAME;
                    res_byte.out_byte = c;
                    n_mode            = MODE_NAME_QUOTED;
                end
                default: begin
                end
            endcase

            // Plain text handling, also after an implicit push
            if (do_text) begin
                if (c == CH_QUOTE) begin
                    n_mode = MODE_QUOTE;
                end else if (r_len == {PB{1'b1}}) begin
                    n_err  = ST_TOO_LONG;
                    n_mode = MODE_HALT;
                end else begin
                    have0             = 1'b1;
                    res_byte.kind     = KIND_TEXT;
                    res_byte.out_byte = c;
                    n_len             = r_len + PB'(1);
                end
            end
        end

        // End of markup: status from the updated state, then clear
        if (i_acc && i_item.end_of_markup) begin
            if (n_err != ST_OK) begin
                st = n_err;
            end else if (n_mode == MODE_QUOTE) begin
                st = ST_TRAIL;
            end else if (n_mode inside {MODE_NAME, MODE_NAME_QUOTED, MODE_NAME_ESCAPE}) begin
                st = ST_OPEN_NAME;
            end else if (n_count != '0) begin
                st = ST_UNCLOSED;
            end else begin
                st = ST_OK;
            end
            res_st.kind     = KIND_STATUS;
            res_st.status   = st;
            res_st.run_last = 1'b1;
            if (have0) begin
                o_entry.cnt = 2'd2;
                o_entry.r0  = res_byte;
                o_entry.r1  = res_st;
            end else begin
                o_entry.cnt = 2'd1;
                o_entry.r0  = res_st;
            end
            n_mode  = MODE_TEXT;
            n_count = '0;
            n_len   = '0;
            n_err   = ST_OK;
        end else if (have0) begin
            res_byte.run_last = 1'b1;
            o_entry.cnt       = 2'd1;
            o_entry.r0        = res_byte;
        end
    end

    assign o_push = (o_entry.cnt != 2'd0);

    // Read the entry under the next top every cycle
    assign rd_sub    = n_count - CW'(1);
    assign raddr     = rd_sub[AW-1:0];
    assign n_fwd_hit = we && (waddr == raddr);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TEXT;
            r_count   <= '0;
            r_len     <= '0;
            r_err     <= ST_OK;
            r_fwd_hit <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_len     <= n_len;
            r_err     <= n_err;
            r_fwd_hit <= n_fwd_hit;
        end
    end

    // Bypass data
    always_ff @(posedge i_clk) begin
        r_fwd_data <= r_len;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_halt_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALT) == (r_err != ST_OK))
        else $error("halt mode and error code disagree");

    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_item.end_of_markup |=> r_count == '0 && r_mode == MODE_TEXT
            && r_len == '0)
        else $error("state not cleared after end of markup");
`endif
endmodule

/* design/ntm_outq.sv */
`timescale 1ns / 1ps
module ntm_outq
    import ntm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    t_entry     r_q [2];
    logic       r_head, r_tail, r_sub;
    logic [1:0] r_fill;
    logic       pop_res;
    logic       pop_ent;
    t_entry     head;

    assign head    = r_q[r_head];
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_sub ? head.r1 : head.r0;
    assign o_space = (r_fill != 2'd2);
    assign pop_res = o_valid && i_ready;
    assign pop_ent = pop_res && (r_sub || head.cnt == 2'd1);

    // Pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_sub  <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_tail <= ~r_tail;
            end
            if (pop_ent) begin
                r_head <= ~r_head;
                r_sub  <= 1'b0;
            end else if (pop_res) begin
                r_sub <= 1'b1;
            end
            r_fill <= r_fill + 2'(i_push) - 2'(pop_ent);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_tail] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("result queue overflow");

    a_sub_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> o_valid && head.cnt == 2'd2)
        else $error("second result selected in a single-result entry");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("result queue fill above two entries");
`endif
endmodule

/* design/nested_tag_markup_parser.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                      Handshake
// i_req     in   in_byte, byte_valid, end_of_markup          valid/ready
// o_res     out  kind, out_byte, tag_begin, tag_end,         valid/ready
//                status, run_last
//
// One request per cycle while i_req.ready is high, decoded in the cycle it is accepted. The open-position
// stack is a RAM read every cycle at the next top, with a bypass for a push to
// that entry, so a close always reads the current top. Results enter a two-entry queue, are
// registered there and leave one per cycle while o_res.ready is high. i_req.ready drops
// only while the queue holds two requests' results. Reset is synchronous,
// active low; the stack RAM needs no clearing.
module nested_tag_markup_parser
    import ntm_pkg::*;
#(
    parameter int STACK_DEPTH   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ntm_req_if.sink   i_req,
    ntm_res_if.source o_res
);
    logic   acc;
    logic   push;
    logic   space;
    t_entry entry;

    assign i_req.ready = space;
    assign acc         = i_req.valid && space;

    // Parser and stack
    ntm_parse #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_item  (i_req.payload),
        .o_push  (push),
        .o_entry (entry)
    );

    // Result queue
    ntm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_space (space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_item  (o_res.payload)
    );
endmodule

/* verif/tb_nested_tag_markup_parser.sv */
`timescale 1ns / 1ps
module tb_nested_tag_markup_parser;
    import ntm_pkg::*;

    localparam int          STACK_DEPTH  = 16;
    localparam int          POS_MAX      = (1 << 16) - 1;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          LONG_HOLD    = 100;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 110;
    localparam int          NO_ST        = -1;

    localparam logic [7:0]  CH_QUOTE   = 8'h27;
    localparam logic [7:0]  CH_LPAREN  = 8'h28;
    localparam logic [7:0]  CH_RPAREN  = 8'h29;
    localparam logic [7:0]  CH_DQUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH  = 8'h5c;

    localparam logic [2:0]  ST_OK             = 3'd0;
    localparam logic [2:0]  ST_TRAILING_QUOTE = 3'd1;
    localparam logic [2:0]  ST_CLOSE_NO_OPEN  = 3'd2;
    localparam logic [2:0]  ST_OPEN_NAME      = 3'd3;
    localparam logic [2:0]  ST_UNCLOSED       = 3'd4;
    localparam logic [2:0]  ST_STACK_FULL     = 3'd5;
    localparam logic [2:0]  ST_TOO_LONG       = 3'd6;

    typedef enum logic [2:0] {
        PM_TEXT, PM_QUOTE, PM_NAME, PM_NAME_QUOTED, PM_NAME_ESCAPE, PM_HALT
    } t_parse_mode;

    // one directed request; st is the status typed in for a markup end, or NO_ST
    typedef struct {
        logic [7:0] b;
        logic       v;
        logic       e;
        int         st;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ntm_req_if markup_req ();
    ntm_res_if markup_res ();

    nested_tag_markup_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (markup_req),
        .o_res   (markup_res)
    );

    // parser shadow state
    t_parse_mode pm;
    logic [15:0] open_pos [STACK_DEPTH];
    int unsigned open_depth;
    logic [16:0] text_len;
    logic [2:0]  err;

    t_out_item   step_results [$];
    t_out_item   expected_results [$];
    int          typed_status_q [$];
    int          fail_count;
    int          idle_cycles;
    int          counted_items;
    bit          calm;
    bit          long_hold_req;

    t_row directed_rows [24] = '{
        '{8'h00,     1'b1, 1'b0, NO_ST},
        '{8'hff,     1'b1, 1'b0, NO_ST},
        '{8'h00,     1'b0, 1'b1, ST_OK},
        // quote left pending at the end
        '{CH_QUOTE,  1'b1, 1'b1, ST_TRAILING_QUOTE},
        // close with nothing open, then an ignored byte
        '{CH_QUOTE,  1'b1, 1'b0, NO_ST},
        '{CH_LPAREN, 1'b1, 1'b0, NO_ST},
        '{8'h78,     1'b1, 1'b1, ST_CLOSE_NO_OPEN},
        // tag around "a", name with a quoted, escaped ')'
        '{CH_QUOTE,  1'b1, 1'b0, NO_ST},
        '{8'h61,     1'b1, 1'b0, NO_ST},
        '{CH_QUOTE,  1'b1, 1'b0, NO_ST},
        '{CH_LPAREN, 1'b1, 1'b0, NO_ST},
        '{CH_DQUOTE, 1'b1, 1'b0, NO_ST},
        '{CH_BSLASH, 1'b1, 1'b0, NO_ST},
        '{CH_RPAREN, 1'b1, 1'b0, NO_ST},
        '{CH_DQUOTE, 1'b1, 1'b0, NO_ST},
        '{CH_RPAREN, 1'b1, 1'b0, NO_ST},
        '{8'h00,     1'b0, 1'b0, NO_ST},
        '{8'h00,     1'b0, 1'b1, ST_OK},
        // quote then quote, close, name left open
        '{CH_QUOTE,  1'b1, 1'b0, NO_ST},
        '{CH_QUOTE,  1'b1, 1'b0, NO_ST},
        '{CH_LPAREN, 1'b1, 1'b0, NO_ST},
        '{8'h00,     1'b0, 1'b1, ST_OPEN_NAME},
        // tag left open
        '{CH_QUOTE,  1'b1, 1'b0, NO_ST},
        '{8'h62,     1'b1, 1'b1, ST_UNCLOSED}
    };

    // clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void reset_parser();
        pm         = PM_TEXT;
        open_depth = 0;
        text_len   = '0;
        err        = ST_OK;
    endfunction

    function automatic void put_result(input logic [2:0] k, input logic [7:0] c,
                                       input logic [15:0] tb, input logic [15:0] te,
                                       input logic [2:0] st);
        t_out_item r;
        r.kind      = k;
        r.out_byte  = c;
        r.tag_begin = tb;
        r.tag_end   = te;
        r.status    = st;
        r.run_last  = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void halt(input logic [2:0] code);
        err = code;
        pm  = PM_HALT;
    endfunction

    function automatic void text_byte(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            pm = PM_QUOTE;
        end else if (text_len >= POS_MAX) begin
            halt(ST_TOO_LONG);
        end else begin
            put_result(KIND_TEXT, c, 16'h0, 16'h0, ST_OK);
            text_len++;
        end
    endfunction

    // results of one markup request, left in step_results
    function automatic void parse_request(input t_in_item it);
        logic [2:0] st;
        step_results.delete();
        if (it.byte_valid) begin
            case (pm)
                PM_TEXT: text_byte(it.in_byte);
                PM_QUOTE: begin
                    if (it.in_byte == CH_LPAREN) begin
                        if (open_depth == 0) begin
                            halt(ST_CLOSE_NO_OPEN);
                        end else begin
                            open_depth--;
                            put_result(KIND_TAG, 8'h00, open_pos[open_depth],
                                       text_len[15:0], ST_OK);
                            pm = PM_NAME;
                        end
                    end else if (open_depth >= STACK_DEPTH) begin
                        halt(ST_STACK_FULL);
                    end else begin
                        open_pos[open_depth] = text_len[15:0];
                        open_depth++;
                        pm = PM_TEXT;
                        text_byte(it.in_byte);
                    end
                end
                PM_NAME: begin
                    if (it.in_byte == CH_RPAREN) begin
                        put_result(KIND_NAME_END, 8'h00, 16'h0, 16'h0, ST_OK);
                        pm = PM_TEXT;
                    end else begin
                        put_result(KIND_NAME, it.in_byte, 16'h0, 16'h0, ST_OK);
                        if (it.in_byte == CH_DQUOTE) pm = PM_NAME_QUOTED;
                    end
                end
                PM_NAME_QUOTED: begin
                    put_result(KIND_NAME, it.in_byte, 16'h0, 16'h0, ST_OK);
                    if (it.in_byte == CH_DQUOTE) pm = PM_NAME;
                    else if (it.in_byte == CH_BSLASH) pm = PM_NAME_ESCAPE;
                end
                PM_NAME_ESCAPE: begin
                    put_result(KIND_NAME, it.in_byte, 16'h0, 16'h0, ST_OK);
                    pm = PM_NAME_QUOTED;
                end
                default: ;
            endcase
        end
        if (it.end_of_markup) begin
            if (err != ST_OK) st = err;
            else if (pm == PM_QUOTE) st = ST_TRAILING_QUOTE;
            else if (pm == PM_NAME || pm == PM_NAME_QUOTED || pm == PM_NAME_ESCAPE)
                st = ST_OPEN_NAME;
            else if (open_depth != 0) st = ST_UNCLOSED;
            else st = ST_OK;
            put_result(KIND_STATUS, 8'h00, 16'h0, 16'h0, st);
            reset_parser();
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].run_last = 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d", got.kind);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind",      16'(want.kind),     16'(got.kind));
        compare_field("out_byte",  16'(want.out_byte), 16'(got.out_byte));
        compare_field("tag_begin", want.tag_begin,     got.tag_begin);
        compare_field("tag_end",   want.tag_end,       got.tag_end);
        compare_field("status",    16'(want.status),   16'(got.status));
        compare_field("run_last",  16'(want.run_last), 16'(got.run_last));
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE) c = 8'h41;
        return c;
    endfunction

    // request and result monitor, watchdog
    always @(posedge i_clk) begin
        t_in_item it;
        int       typed;
        if (i_rst_n) begin
            if (markup_req.valid && markup_req.ready) begin
                it = markup_req.payload;
                parse_request(it);
                typed = typed_status_q.pop_front();
                if (typed != NO_ST)
                    step_results[step_results.size() - 1].status = 3'(typed);
                foreach (step_results[k])
                    expected_results.insert(expected_results.size(), step_results[k]);
            end
            if (markup_res.valid && markup_res.ready) check_result(markup_res.payload);
            if ((markup_req.valid && markup_req.ready) ||
                (markup_res.valid && markup_res.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result sink: random stalls, one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        markup_res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                markup_res.ready <= 1'b0;
                stall_left--;
            end else begin
                markup_res.ready <= 1'b1;
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_item(input logic [7:0] b, input logic v, input logic e,
                             input int typed);
        int unsigned gap;
        t_in_item    it;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            markup_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.in_byte       = b;
        it.byte_valid    = v;
        it.end_of_markup = e;
        typed_status_q.insert(typed_status_q.size(), typed);
        markup_req.valid   <= 1'b1;
        markup_req.payload <= it;
        do @(posedge i_clk); while (!markup_req.ready);
        if (v || e) counted_items++;
    endtask

    // tag name up to ')', with quoted stretches and escapes
    task automatic send_name();
        int unsigned len;
        bit          quoted;
        bit          escaped;
        logic [7:0]  c;
        len     = $urandom_range(0, 6);
        quoted  = 1'b0;
        escaped = 1'b0;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) c = CH_DQUOTE;
            else if (quoted && $urandom_range(0, 3) == 0) c = CH_BSLASH;
            else c = 8'($urandom_range(0, 255));
            if (!quoted && c == CH_RPAREN) c = 8'h6e;
            send_item(c, 1'b1, 1'b0, NO_ST);
            if (escaped) escaped = 1'b0;
            else if (quoted && c == CH_DQUOTE) quoted = 1'b0;
            else if (quoted && c == CH_BSLASH) escaped = 1'b1;
            else if (!quoted && c == CH_DQUOTE) quoted = 1'b1;
        end
        if (escaped) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_ST);
        if (quoted) send_item(CH_DQUOTE, 1'b1, 1'b0, NO_ST);
        send_item(CH_RPAREN, 1'b1, 1'b0, NO_ST);
    endtask

    task automatic send_close();
        send_item(CH_QUOTE, 1'b1, 1'b0, NO_ST);
        send_item(CH_LPAREN, 1'b1, 1'b0, NO_ST);
        send_name();
    endtask

    // one markup string: mostly well nested, some noise and broken endings
    task automatic send_random_markup();
        int unsigned n_tok;
        int unsigned depth;
        int unsigned pick;
        int unsigned text_th;
        int unsigned open_th;
        bit          deep;
        deep    = ($urandom_range(0, 7) == 0);
        n_tok   = deep ? $urandom_range(20, 40) : $urandom_range(1, 12);
        text_th = deep ? 10 : 35;
        open_th = deep ? 85 : 60;
        depth   = 0;
        for (int i = 0; i < n_tok; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < text_th) begin
                send_item(plain_byte(), 1'b1, 1'b0, NO_ST);
            end else if (pick < open_th) begin
                send_item(CH_QUOTE, 1'b1, 1'b0, NO_ST);
                depth++;
            end else if (pick < 90 && depth > 0) begin
                send_close();
                depth--;
            end else if (pick < 95) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_ST);
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_ST);
            end
        end
        if ($urandom_range(0, 1) == 0) begin
            while (depth > 0) begin
                send_close();
                depth--;
            end
        end
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, NO_ST);
    endtask

    // stimulus
    initial begin
        fail_count    = 0;
        idle_cycles   = 0;
        counted_items = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        reset_parser();
        i_rst_n            <= 1'b0;
        markup_req.valid   <= 1'b0;
        markup_req.payload <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].b, directed_rows[r].v, directed_rows[r].e,
                      directed_rows[r].st);

        // stack overflow: the eighteenth quote pushes onto a full stack
        repeat (18) send_item(CH_QUOTE, 1'b1, 1'b0, NO_ST);
        send_item(8'h00, 1'b0, 1'b1, ST_STACK_FULL);

        // random markup: a stretch with no idling, then gaps and a long hold-off
        calm          = 1'b1;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS / 4) send_random_markup();
        calm          = 1'b0;
        long_hold_req = 1'b1;
        while (counted_items < RANDOM_ITEMS) send_random_markup();

        markup_req.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
